@@ src/bxd_pkg.sv @@
// ----------------------------------------------------------------------------
// bxd_pkg - shared types and constants for the packet deframer
// Item codes, queue entry layout, parser phases, reply bytes and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package bxd_pkg;

  // Largest outer payload accepted in one packet
  localparam logic [7:0] MAX_OUTER_PAYLOAD = 8'd126;

  // Queue depth between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Reply bytes sent back over the link
  localparam logic [7:0] REPLY_ACK = 8'h60;
  localparam logic [7:0] REPLY_NAK = 8'hA8;

  // Input action codes
  localparam logic [1:0] ACT_BYTE  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_FLUSH = 2'd2;

  // Result kinds
  localparam logic KIND_BODY  = 1'b0;
  localparam logic KIND_REPLY = 1'b1;

  // Classified operation carried through the queue
  typedef enum logic [1:0] {
    OP_BYTE,
    OP_START,
    OP_FLUSH
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;   // already bit-reversed
  } item_t;

  // Outer packet parser phase
  typedef enum logic [2:0] {
    PH_HEADER,
    PH_PAYLOAD,
    PH_CHECK,
    PH_DISCARD,
    PH_ENDED
  } phase_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_BUSY,
    ST_DONE_OK,
    ST_TOO_SHORT,
    ST_INNER_BAD,
    ST_BAD_LENGTH,
    ST_OUTER_BAD
  } status_t;

  // Push side of the queue
  typedef struct packed {
    logic  valid;
    item_t item;
  } push_t;

endpackage

`default_nettype wire

@@ src/bitrev_xor_packet_deframer.sv @@
// An input beat is queued; the parser pops it and registers its result.
// Throughput: one input beat per cycle unless the queue is full; the parser retires
//   one queued item per cycle whenever its output register is free or being taken.
// A four-entry queue separates the input side from the parser and result.
// Reset (rst, synchronous): empties the queue and output register and puts
//   the parser in the wait-for-header state with an inner size of 126.
// ----------------------------------------------------------------------------
// bitrev_xor_packet_deframer - top level
// Bit-reversed serial byte deframer with outer and inner XOR checks, giving
// tentative body bytes and ACK/NAK reply beats.
// ----------------------------------------------------------------------------
`default_nettype none

module bitrev_xor_packet_deframer (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] action,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            kind,
  output logic [7:0]      out_byte,
  output logic [2:0]      status,
  output logic            last
);
  import bxd_pkg::*;

  push_t push;
  item_t head;
  logic  q_full;
  logic  q_empty;
  logic  pop;

  bxd_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .action   (action),
    .rx_byte  (rx_byte),
    .q_full   (q_full),
    .push     (push)
  );

  bxd_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (q_full),
    .empty (q_empty),
    .pop   (pop),
    .head  (head)
  );

  bxd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .out_byte  (out_byte),
    .status    (status),
    .last      (last)
  );

endmodule

`default_nettype wire

@@ src/bxd_front.sv @@
// ----------------------------------------------------------------------------
// bxd_front - input stage of the deframer
// Takes input beats, bit-reverses the byte, classifies the action and pushes
// meaningful items into the queue. Unused action codes are swallowed.
// ----------------------------------------------------------------------------
`default_nettype none

module bxd_front (
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic [1:0]   action,
  input  wire logic [7:0]   rx_byte,
  input  wire logic         q_full,
  output bxd_pkg::push_t    push
);
  import bxd_pkg::*;

  logic [7:0] flipped;
  op_t        op;
  logic       keep;

  // Bit reversal: bit 0 <-> bit 7 and so on
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      flipped[7 - k] = rx_byte[k];
    end
  end

  // Classify the action; unused code is dropped
  always_comb begin
    op   = OP_BYTE;
    keep = 1'b1;
    case (action)
      ACT_BYTE:  op = OP_BYTE;
      ACT_START: op = OP_START;
      ACT_FLUSH: op = OP_FLUSH;
      default:   keep = 1'b0;
    endcase
  end

  assign in_stall        = q_full;
  assign push.valid      = in_valid && !q_full && keep;
  assign push.item.op    = op;
  assign push.item.data  = flipped;

endmodule

`default_nettype wire

@@ src/bxd_queue.sv @@
// ----------------------------------------------------------------------------
// bxd_queue - short FIFO between front and back
// Small register FIFO so that each side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module bxd_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire bxd_pkg::push_t push,
  output logic                full,
  output logic                empty,
  input  wire logic           pop,
  output bxd_pkg::item_t      head
);
  import bxd_pkg::*;

  item_t               slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;
  logic                do_push;
  logic                do_pop;

  assign full    = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push.valid && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push.item;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QUEUE_AW+1)'(QUEUE_DEPTH))
    else $error("queue fill level beyond depth");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (count == $past(count) + 1'b1))
    else $error("queue fill level missed a push");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (QUEUE_AW'(rd_ptr + count[QUEUE_AW-1:0]) == wr_ptr))
    else $error("queue pointers disagree with fill level");
`endif

endmodule

`default_nettype wire

@@ src/bxd_back.sv @@
// ----------------------------------------------------------------------------
// bxd_back - packet parser and result register
// Pops classified items, runs the outer/inner packet state and holds at most
// one result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bxd_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_empty,
  input  wire bxd_pkg::item_t  head,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic                 kind,
  output logic [7:0]           out_byte,
  output logic [2:0]           status,
  output logic                 last
);
  import bxd_pkg::*;

  // Parser state
  phase_t      phase, phase_next;
  logic [7:0]  outer_length, outer_length_next;
  logic [7:0]  outer_position, outer_position_next;
  logic [7:0]  outer_parity, outer_parity_next;
  logic [16:0] inner_received, inner_received_next;
  logic [16:0] inner_expected, inner_expected_next;
  logic [7:0]  inner_parity, inner_parity_next;
  logic [7:0]  pending_inner_parity, pending_inner_parity_next;
  logic [7:0]  size_low_byte, size_low_byte_next;

  // Result of the current item
  logic        res_valid;
  logic        res_kind;
  logic [7:0]  res_byte;
  status_t     res_status;
  logic        res_last;

  // Shared arithmetic
  logic [7:0]  b;
  logic [16:0] gap;
  logic [7:0]  room;
  logic [17:0] idx;
  logic        idx_in;
  logic        idx_body;
  logic [16:0] size_total;
  logic [7:0]  pos_inc;
  logic [16:0] recv_sum;

  assign b   = head.data;
  assign pop = !q_empty && (!out_valid || !out_stall);

  // Room left in the inner message, capped at one packet
  always_comb begin
    gap = inner_expected - inner_received;
    if (inner_expected <= inner_received) begin
      room = 8'd0;
    end else if (gap > 17'(MAX_OUTER_PAYLOAD)) begin
      room = MAX_OUTER_PAYLOAD;
    end else begin
      room = gap[7:0];
    end
  end

  assign idx        = {1'b0, inner_received} + 18'(outer_position);
  assign idx_in     = idx < {1'b0, inner_expected};
  assign idx_body   = (19'(idx) + 19'd1) < 19'(inner_expected);
  assign size_total = 17'({b, size_low_byte}) + 17'd3;
  assign pos_inc    = outer_position + 8'd1;
  assign recv_sum   = inner_received + 17'(outer_length);

  // Next state and result
  always_comb begin
    phase_next                = phase;
    outer_length_next         = outer_length;
    outer_position_next       = outer_position;
    outer_parity_next         = outer_parity;
    inner_received_next       = inner_received;
    inner_expected_next       = inner_expected;
    inner_parity_next         = inner_parity;
    pending_inner_parity_next = pending_inner_parity;
    size_low_byte_next        = size_low_byte;
    res_valid                 = 1'b0;
    res_kind                  = KIND_BODY;
    res_byte                  = b;
    res_status                = ST_BUSY;
    res_last                  = 1'b0;

    if (pop) begin
      case (head.op)
        OP_START: begin
          phase_next                = PH_HEADER;
          outer_length_next         = '0;
          outer_position_next       = '0;
          outer_parity_next         = '0;
          inner_received_next       = '0;
          inner_expected_next       = 17'(MAX_OUTER_PAYLOAD);
          inner_parity_next         = '0;
          pending_inner_parity_next = '0;
          size_low_byte_next        = '0;
        end
        OP_FLUSH: begin
          if (phase != PH_ENDED) begin
            if (phase inside {PH_PAYLOAD, PH_CHECK}) begin
              pending_inner_parity_next = inner_parity;
              if (inner_received == '0) begin
                inner_expected_next = 17'(MAX_OUTER_PAYLOAD);
              end
            end
            phase_next = PH_HEADER;
          end
        end
        OP_BYTE: begin
          case (phase)
            PH_HEADER: begin
              if (b > room) begin
                phase_next = PH_DISCARD;
                res_valid  = 1'b1;
                res_kind   = KIND_REPLY;
                res_byte   = REPLY_NAK;
                res_status = ST_BAD_LENGTH;
              end else begin
                outer_length_next         = b;
                outer_parity_next         = b;
                outer_position_next       = '0;
                pending_inner_parity_next = inner_parity;
                phase_next = (b == 8'd0) ? PH_CHECK : PH_PAYLOAD;
              end
            end
            PH_PAYLOAD: begin
              if (idx_in) begin
                pending_inner_parity_next = pending_inner_parity ^ b;
                if (idx == '0) begin
                  size_low_byte_next = b;
                end else if (idx == 18'd1) begin
                  inner_expected_next = size_total;
                end else if (idx_body) begin
                  res_valid = 1'b1;
                end
              end
              outer_parity_next   = outer_parity ^ b;
              outer_position_next = pos_inc;
              if (pos_inc >= outer_length) begin
                phase_next = PH_CHECK;
              end
            end
            PH_CHECK: begin
              res_valid = 1'b1;
              res_kind  = KIND_REPLY;
              if (b != outer_parity) begin
                // Outer checksum bad: drop the packet
                pending_inner_parity_next = inner_parity;
                if (inner_received == '0) begin
                  inner_expected_next = 17'(MAX_OUTER_PAYLOAD);
                end
                phase_next = PH_HEADER;
                res_byte   = REPLY_NAK;
                res_status = ST_OUTER_BAD;
              end else begin
                inner_received_next = recv_sum;
                inner_parity_next   = pending_inner_parity;
                res_byte            = REPLY_ACK;
                if (inner_received == '0 && outer_length < 8'd2) begin
                  phase_next = PH_ENDED;
                  res_status = ST_TOO_SHORT;
                  res_last   = 1'b1;
                end else if (recv_sum >= inner_expected) begin
                  phase_next = PH_ENDED;
                  res_status = (pending_inner_parity == '0) ? ST_DONE_OK : ST_INNER_BAD;
                  res_last   = 1'b1;
                end else begin
                  phase_next = PH_HEADER;
                end
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // Parser state register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase                <= PH_HEADER;
      outer_length         <= '0;
      outer_position       <= '0;
      outer_parity         <= '0;
      inner_received       <= '0;
      inner_expected       <= 17'(MAX_OUTER_PAYLOAD);
      inner_parity         <= '0;
      pending_inner_parity <= '0;
      size_low_byte        <= '0;
    end else begin
      phase                <= phase_next;
      outer_length         <= outer_length_next;
      outer_position       <= outer_position_next;
      outer_parity         <= outer_parity_next;
      inner_received       <= inner_received_next;
      inner_expected       <= inner_expected_next;
      inner_parity         <= inner_parity_next;
      pending_inner_parity <= pending_inner_parity_next;
      size_low_byte        <= size_low_byte_next;
    end
  end

  // Output register valid bit: loads whenever an item is popped, else clears once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= res_valid;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && res_valid) begin
      kind     <= res_kind;
      out_byte <= res_byte;
      status   <= res_status;
      last     <= res_last;
    end
  end

`ifndef SYNTHESIS
  a_body_plain: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_BODY) |-> (status == ST_BUSY && !last))
    else $error("body beat carries a status or end mark");

  a_pos_in_packet: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD) |-> (outer_position < outer_length))
    else $error("payload position past packet length");

  a_no_pop_when_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !pop)
    else $error("item popped while result held");

  a_end_reply: assert property (@(posedge clk) disable iff (rst)
    (pop && res_last) |=> (phase == PH_ENDED && out_valid && kind == KIND_REPLY))
    else $error("message end without reply or ended phase");
`endif

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb - self-checking bench for bitrev_xor_packet_deframer
// Sends transfers of outer packets built from random inner messages. Most are
// well formed; some carry bad checksums, oversize headers, early flushes or
// stray beats. Every result beat is checked against an untimed model of the
// deframer, with random idling and stalling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import bxd_pkg::*;

// Action code with no meaning; the block must ignore it
localparam logic [1:0] ACT_SPARE = 2'd3;

typedef struct {
  logic       kind;
  logic [7:0] data;
  logic [2:0] status;
  logic       last;
} deframe_result_t;

// Line bytes arrive with their bit order swapped
function automatic logic [7:0] bit_flip(logic [7:0] v);
  logic [7:0] r;
  for (int k = 0; k < 8; k++) r[7-k] = v[k];
  return r;
endfunction

// Untimed deframer model plus the queue of result beats still due
class deframe_tracker;
  phase_t          phase;
  logic [7:0]      pkt_len;
  logic [7:0]      pkt_pos;
  logic [7:0]      pkt_xor;
  logic [16:0]     msg_got;
  logic [16:0]     msg_size;
  logic [7:0]      msg_xor;
  logic [7:0]      msg_xor_open;
  logic [7:0]      size_lo;
  deframe_result_t due_q[$];
  int              errors;

  function new();
    errors = 0;
    restart();
  endfunction

  function void restart();
    phase        = PH_HEADER;
    pkt_len      = '0;
    pkt_pos      = '0;
    pkt_xor      = '0;
    msg_got      = '0;
    msg_size     = 17'(MAX_OUTER_PAYLOAD);
    msg_xor      = '0;
    msg_xor_open = '0;
    size_lo      = '0;
  endfunction

  // A dropped packet forgets its inner XOR, and its size if it was the first
  function void drop_open_packet();
    msg_xor_open = msg_xor;
    if (msg_got == 0) msg_size = 17'(MAX_OUTER_PAYLOAD);
  endfunction

  function void due(logic k, logic [7:0] d, status_t st, logic l);
    deframe_result_t r;
    r.kind   = k;
    r.data   = d;
    r.status = st;
    r.last   = l;
    due_q.push_back(r);
  endfunction

  // Called for every accepted input beat
  function void note_beat(logic [1:0] act, logic [7:0] raw);
    logic [7:0]  b;
    logic [16:0] room;
    int unsigned idx;
    logic        first;
    b = bit_flip(raw);
    if (act == ACT_START) begin
      restart();
    end else if (act == ACT_FLUSH) begin
      if (phase != PH_ENDED) begin
        if (phase == PH_PAYLOAD || phase == PH_CHECK) drop_open_packet();
        phase = PH_HEADER;
      end
    end else if (act == ACT_BYTE) begin
      case (phase)
        PH_HEADER: begin
          // room left in the inner message, capped at one packet
          room = (msg_size > msg_got) ? msg_size - msg_got : '0;
          if (room > 17'(MAX_OUTER_PAYLOAD)) room = 17'(MAX_OUTER_PAYLOAD);
          if (17'(b) > room) begin
            phase = PH_DISCARD;
            due(KIND_REPLY, REPLY_NAK, ST_BAD_LENGTH, 1'b0);
          end else begin
            pkt_len      = b;
            pkt_xor      = b;
            pkt_pos      = '0;
            msg_xor_open = msg_xor;
            phase        = (b == 0) ? PH_CHECK : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          idx = 32'(msg_got) + 32'(pkt_pos);
          // bytes past the inner size only count towards the outer XOR
          if (idx < 32'(msg_size)) begin
            msg_xor_open ^= b;
            if (idx == 0) size_lo = b;
            else if (idx == 1) msg_size = 17'({b, size_lo}) + 17'd3;
            else if (idx + 1 < 32'(msg_size)) due(KIND_BODY, b, ST_BUSY, 1'b0);
          end
          pkt_xor ^= b;
          pkt_pos++;
          if (pkt_pos >= pkt_len) phase = PH_CHECK;
        end
        PH_CHECK: begin
          if (b != pkt_xor) begin
            drop_open_packet();
            phase = PH_HEADER;
            due(KIND_REPLY, REPLY_NAK, ST_OUTER_BAD, 1'b0);
          end else begin
            first   = (msg_got == 0);
            msg_got = msg_got + 17'(pkt_len);
            msg_xor = msg_xor_open;
            if (first && pkt_len < 2) begin
              phase = PH_ENDED;
              due(KIND_REPLY, REPLY_ACK, ST_TOO_SHORT, 1'b1);
            end else if (msg_got >= msg_size) begin
              phase = PH_ENDED;
              due(KIND_REPLY, REPLY_ACK, (msg_xor == 0) ? ST_DONE_OK : ST_INNER_BAD, 1'b1);
            end else begin
              phase = PH_HEADER;
              due(KIND_REPLY, REPLY_ACK, ST_BUSY, 1'b0);
            end
          end
        end
        default: ;
      endcase
    end
  endfunction

  task report(string msg);
    errors++;
    if (errors <= 40) $display("%0t MISMATCH %s", $time, msg);
  endtask

  // Called for every accepted result beat
  task check_beat(logic k, logic [7:0] d, logic [2:0] st, logic l);
    deframe_result_t r;
    if (due_q.size() == 0) begin
      report($sformatf("unexpected beat kind=%0d byte=%02h status=%0d last=%0d",
                       k, d, st, l));
      return;
    end
    r = due_q.pop_front();
    if (k !== r.kind) report($sformatf("kind %0d, want %0d", k, r.kind));
    if (d !== r.data) report($sformatf("out_byte %02h, want %02h", d, r.data));
    if (st !== r.status) report($sformatf("status %0d, want %0d", st, r.status));
    if (l !== r.last) report($sformatf("last %0d, want %0d", l, r.last));
  endtask

  function int pending();
    return due_q.size();
  endfunction

  task check_drained();
    if (due_q.size() != 0) report($sformatf("%0d beats never arrived", due_q.size()));
  endtask
endclass

module tb;
  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] action;
  logic [7:0] rx_byte;
  logic       out_valid;
  logic       out_stall;
  logic       kind;
  logic [7:0] out_byte;
  logic [2:0] status;
  logic       last;

  deframe_tracker tracker;
  logic [7:0]     msg_q[$];
  int             beats_sent;
  int             idle_pct;
  int             stall_pct;

  bitrev_xor_packet_deframer DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .out_byte  (out_byte),
    .status    (status),
    .last      (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("tb failed");
    $finish;
  end

  // One input beat, with an optional idle burst in front of it
  task automatic send_item(logic [1:0] act, logic [7:0] raw);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    rx_byte  <= raw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_beat(act, raw);
    if (act != ACT_SPARE) beats_sent++;
  endtask

  task automatic send_byte(logic [7:0] v);
    send_item(ACT_BYTE, bit_flip(v));
  endtask

  // Header, payload taken from the message (random filler past its end), checksum
  task automatic send_packet(int first, int len, bit bad_sum);
    logic [7:0] sum;
    logic [7:0] v;
    sum = 8'(len);
    send_byte(sum);
    for (int i = 0; i < len; i++) begin
      v = (first + i < msg_q.size()) ? msg_q[first + i] : 8'($urandom);
      sum ^= v;
      send_byte(v);
    end
    if (bad_sum) sum ^= 8'($urandom_range(1, 255));
    send_byte(sum);
  endtask

  // One transfer: start, then the inner message split into outer packets,
  // with faults injected before some of them
  task automatic send_message();
    int         size;
    int         n;
    int         pos;
    int         len;
    int         cap;
    int         roll;
    logic [7:0] acc;
    send_item(ACT_START, 8'($urandom));
    roll = $urandom_range(0, 99);
    size = (roll < 70) ? $urandom_range(0, 20) :
           (roll < 96) ? $urandom_range(21, 130) : $urandom_range(200, 300);
    msg_q.delete();
    msg_q.push_back(8'(size));
    msg_q.push_back(8'(size >> 8));
    repeat (size) msg_q.push_back(8'($urandom));
    acc = '0;
    foreach (msg_q[i]) acc ^= msg_q[i];
    if ($urandom_range(0, 99) < 15) acc ^= 8'($urandom_range(1, 255));
    msg_q.push_back(acc);
    n = msg_q.size();

    // first packet too short to hold the size
    if ($urandom_range(0, 99) < 8) begin
      send_packet(0, $urandom_range(0, 1), 1'b0);
      return;
    end

    pos = 0;
    while (pos < n) begin
      cap = (pos == 0) ? int'(MAX_OUTER_PAYLOAD) : n - pos;
      if (cap > int'(MAX_OUTER_PAYLOAD)) cap = int'(MAX_OUTER_PAYLOAD);
      if (pos == 0)
        len = ($urandom_range(0, 99) < 15 && n < cap) ? $urandom_range(n, cap) :
              $urandom_range(2, (n < cap) ? n : cap);
      else if ($urandom_range(0, 99) < 5)
        len = 0;
      else
        len = $urandom_range(1, cap);

      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        send_packet(pos, len, 1'b1);
      end else if (roll < 13) begin
        // oversize header, some discarded beats, then a flush
        send_byte(8'($urandom_range(cap + 1, 255)));
        repeat ($urandom_range(0, 3)) send_item(ACT_BYTE, 8'($urandom));
        send_item(ACT_FLUSH, 8'($urandom));
      end else if (roll < 18) begin
        // packet cut short by a flush
        send_byte(8'(len));
        repeat ($urandom_range(0, len)) send_item(ACT_BYTE, 8'($urandom));
        send_item(ACT_FLUSH, 8'($urandom));
      end else if (roll < 21) begin
        case ($urandom_range(0, 2))
          0:       send_item(ACT_BYTE, 8'($urandom));
          1:       send_item(ACT_FLUSH, 8'($urandom));
          default: send_item(ACT_SPARE, 8'($urandom));
        endcase
      end
      send_packet(pos, len, 1'b0);
      pos += len;
    end

    // stray beats after the message has ended
    if ($urandom_range(0, 99) < 20)
      repeat ($urandom_range(1, 3)) send_item(2'($urandom_range(0, 3)), 8'($urandom));
  endtask

  // Result side: check accepted beats, stall in random bursts
  initial begin : sink
    int hold;
    hold = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) tracker.check_beat(kind, out_byte, status, last);
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        hold = $urandom_range(1, 9) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    int waited;
    tracker    = new();
    beats_sent = 0;
    idle_pct   = 0;
    stall_pct  = 0;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    action   <= ACT_BYTE;
    rx_byte  <= 8'h00;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: oversize header, discard and flush, unused action
    send_item(ACT_START, 8'hFF);
    send_item(ACT_SPARE, 8'h00);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_item(ACT_FLUSH, 8'hA5);
    // first packet of one byte, then beats ignored once ended
    send_byte(8'h01);
    send_byte(8'h80);
    send_byte(8'h81);
    send_item(ACT_BYTE, 8'h33);
    send_item(ACT_FLUSH, 8'h00);
    // empty first packet
    send_item(ACT_START, 8'h00);
    send_byte(8'h00);
    send_byte(8'h00);
    // one body byte, packet longer than the inner message
    send_item(ACT_START, 8'h00);
    msg_q = '{8'h01, 8'h00, 8'hFF, 8'hFE};
    send_packet(0, 6, 1'b0);

    // Random transfers; the tail of the run goes without idling or stalling
    while (beats_sent < 950) begin
      if (beats_sent > 850) begin
        idle_pct  = 0;
        stall_pct = 0;
      end else begin
        case ($urandom_range(0, 2))
          0:       idle_pct = 0;
          1:       idle_pct = 10;
          default: idle_pct = 35;
        endcase
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 10;
          default: stall_pct = 35;
        endcase
      end
      send_message();
    end
    in_valid <= 1'b0;

    waited = 0;
    while (tracker.pending() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (12) @(posedge clk);
    tracker.check_drained();
    if (tracker.errors == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end
endmodule

@@ sim.f @@
src/bxd_pkg.sv
src/bxd_front.sv
src/bxd_queue.sv
src/bxd_back.sv
src/bitrev_xor_packet_deframer.sv
sim/tb.sv
